// ===== rtl/pdm_pkg.sv =====
// Package for palette_distance_merge: sizes, field types and sequencer states.
// No dependencies.
package pdm_pkg;

    localparam int MaxEntries = 64;
    localparam int IdxW       = $clog2(MaxEntries);
    localparam int CntW       = IdxW + 1;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] pixel_count;
        logic        last_entry;
    } t_in_item;

    typedef struct packed {
        logic [5:0] entry_index;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       is_survivor;
        logic [6:0] survivor_total;
        logic [6:0] loaded_total;
        logic       last_result;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RANK_KEY,
        ST_RANK_RD,
        ST_RANK_CNT,
        ST_RANK_CMP,
        ST_RANK_PUT,
        ST_OUTER_RD,
        ST_OUTER_CHK,
        ST_OUTER_COL,
        ST_INNER_RD,
        ST_INNER_CMP,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/pdm_if.sv =====
// Valid/ready channel carrying one transaction of type T.
// Depends on pdm_pkg for the payload types.
interface pdm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pdm_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pdm_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/palette_distance_merge.sv =====
// Top level of palette_distance_merge: load, rank, merge and emit sequencer.
// Depends on pdm_pkg, pdm_if and pdm_ram.
//
// Entries load at one per cycle. The entry flagged last closes the load; no
// further input is taken until the last result of that load sits in the
// output register, and the next load's results wait until it is taken.
// Ranking is an insertion sort over the order memory. The greedy merge visits
// each ranked entry and compares it with the entries ranked after it.
// Emission of each entry can be held by an output stall. All memory traffic
// goes through single-read RAMs. The alive flag of each entry is kept as the
// top bit of the colour memory.
module palette_distance_merge (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [8:0]       i_cfg_wdata,
    pdm_if.sink              in_if,
    pdm_if.source            out_if
);
    localparam int IW = pdm_pkg::IdxW;
    localparam int CW = pdm_pkg::CntW;

    pdm_pkg::t_state r_state, n_state;
    logic [8:0]    r_maxd;
    logic [CW-1:0] r_n;       // load count
    logic [CW-1:0] r_k, r_m;  // rank loop indexes; reused as outer/inner
    logic [CW-1:0] r_surv;
    logic [23:0]   r_key_cnt;
    logic [23:0]   r_rep_col;
    logic [17:0]   r_d2;
    logic          r_ovalid;
    pdm_pkg::t_out_item r_out;

    // memory ports; colour word is {alive, red, green, blue}
    logic          col_we, cnt_we, ord_we;
    logic [IW-1:0] col_wa, cnt_wa, ord_wa, col_ra, cnt_ra, ord_ra;
    logic [24:0]   col_wd, col_rd;
    logic [23:0]   cnt_wd, cnt_rd;
    logic [IW-1:0] ord_wd, ord_rd;

    pdm_ram #(.Width(25), .Depth(pdm_pkg::MaxEntries)) u_col (
        .i_clk, .i_we(col_we), .i_waddr(col_wa), .i_wdata(col_wd),
        .i_raddr(col_ra), .o_rdata(col_rd));
    pdm_ram #(.Width(24), .Depth(pdm_pkg::MaxEntries)) u_cnt (
        .i_clk, .i_we(cnt_we), .i_waddr(cnt_wa), .i_wdata(cnt_wd),
        .i_raddr(cnt_ra), .o_rdata(cnt_rd));
    pdm_ram #(.Width(IW), .Depth(pdm_pkg::MaxEntries)) u_ord (
        .i_clk, .i_we(ord_we), .i_waddr(ord_wa), .i_wdata(ord_wd),
        .i_raddr(ord_ra), .o_rdata(ord_rd));

    // order entry order[m-1], held while its count is read
    logic [IW-1:0] r_ord_q;

    // inner loop: colour read the cycle after its order entry
    logic [IW-1:0] r_q;
    logic          r_cmp_pend;

    logic          in_acc, out_acc;
    logic          load_room;
    assign in_acc    = in_if.valid && in_if.ready;
    assign out_acc   = out_if.valid && out_if.ready;
    assign load_room = (r_n < CW'(pdm_pkg::MaxEntries));

    // squared distance between representative and the colour just read
    logic [8:0]  dr, dg, db;
    logic [18:0] dist2;
    always_comb begin
        dr = {1'b0, r_rep_col[23:16]} - {1'b0, col_rd[23:16]};
        dg = {1'b0, r_rep_col[15:8]}  - {1'b0, col_rd[15:8]};
        db = {1'b0, r_rep_col[7:0]}   - {1'b0, col_rd[7:0]};
        if (dr[8]) dr = -dr;
        if (dg[8]) dg = -dg;
        if (db[8]) db = -db;
        dist2 = 19'(dr[7:0] * dr[7:0]) + 19'(dg[7:0] * dg[7:0])
              + 19'(db[7:0] * db[7:0]);
    end

    logic rank_shift, merge_hit, emit_load;
    assign rank_shift = (cnt_rd < r_key_cnt);
    assign merge_hit  = r_cmp_pend && col_rd[24] && ({1'b0, dist2} < {2'b0, r_d2});
    assign emit_load  = (r_state == pdm_pkg::ST_EMIT) && (!r_ovalid || out_acc);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdm_pkg::ST_LOAD: begin
                if (in_acc && in_if.data.last_entry) begin
                    n_state = pdm_pkg::ST_RANK_KEY;
                end
            end
            pdm_pkg::ST_RANK_KEY: begin
                if (r_k >= r_n) n_state = pdm_pkg::ST_OUTER_RD;
                else n_state = pdm_pkg::ST_RANK_RD;
            end
            pdm_pkg::ST_RANK_RD: begin
                if (r_m == '0) n_state = pdm_pkg::ST_RANK_PUT;
                else n_state = pdm_pkg::ST_RANK_CNT;
            end
            pdm_pkg::ST_RANK_CNT:  n_state = pdm_pkg::ST_RANK_CMP;
            pdm_pkg::ST_RANK_CMP: begin
                if (rank_shift) n_state = pdm_pkg::ST_RANK_RD;
                else n_state = pdm_pkg::ST_RANK_PUT;
            end
            pdm_pkg::ST_RANK_PUT:  n_state = pdm_pkg::ST_RANK_KEY;
            pdm_pkg::ST_OUTER_RD: begin
                if (r_k >= r_n) n_state = pdm_pkg::ST_EMIT_RD;
                else n_state = pdm_pkg::ST_OUTER_CHK;
            end
            pdm_pkg::ST_OUTER_CHK: n_state = pdm_pkg::ST_OUTER_COL;
            pdm_pkg::ST_OUTER_COL: begin
                if (col_rd[24]) n_state = pdm_pkg::ST_INNER_RD;
                else n_state = pdm_pkg::ST_OUTER_RD;
            end
            pdm_pkg::ST_INNER_RD: begin
                if (r_m >= r_n) n_state = pdm_pkg::ST_OUTER_RD;
                else n_state = pdm_pkg::ST_INNER_CMP;
            end
            pdm_pkg::ST_INNER_CMP: n_state = pdm_pkg::ST_INNER_RD;
            pdm_pkg::ST_EMIT_RD: begin
                if (r_k >= r_n) n_state = pdm_pkg::ST_LOAD;
                else n_state = pdm_pkg::ST_EMIT;
            end
            pdm_pkg::ST_EMIT: begin
                if (emit_load) n_state = pdm_pkg::ST_EMIT_RD;
            end
            default: n_state = pdm_pkg::ST_LOAD;
        endcase
    end

    // memory addressing; a merge writes the representative colour and kills the entry
    always_comb begin
        col_we = 1'b0;
        cnt_we = 1'b0;
        ord_we = 1'b0;
        col_wa = r_n[IW-1:0];
        cnt_wa = r_n[IW-1:0];
        ord_wa = r_m[IW-1:0];
        col_wd = {1'b1, in_if.data.red, in_if.data.green, in_if.data.blue};
        cnt_wd = in_if.data.pixel_count;
        ord_wd = r_k[IW-1:0];
        col_ra = r_k[IW-1:0];
        cnt_ra = r_k[IW-1:0];
        ord_ra = r_k[IW-1:0];
        unique case (r_state)
            pdm_pkg::ST_LOAD: begin
                col_we = in_acc && load_room;
                cnt_we = in_acc && load_room;
            end
            pdm_pkg::ST_RANK_RD:   ord_ra = IW'(r_m - 1'b1);
            pdm_pkg::ST_RANK_CNT:  cnt_ra = ord_rd;
            pdm_pkg::ST_RANK_CMP: begin
                // shift entry up when it loses
                ord_we = rank_shift;
                ord_wd = r_ord_q;
            end
            pdm_pkg::ST_RANK_PUT:  ord_we = 1'b1;
            pdm_pkg::ST_OUTER_CHK: col_ra = ord_rd;
            pdm_pkg::ST_INNER_RD:  ord_ra = r_m[IW-1:0];
            pdm_pkg::ST_INNER_CMP: col_ra = ord_rd;
            default: ;
        endcase
        if (merge_hit) begin
            col_we = 1'b1;
            col_wa = r_q;
            col_wd = {1'b0, r_rep_col};
        end
    end

    assign in_if.ready  = (r_state == pdm_pkg::ST_LOAD);
    assign out_if.valid = r_ovalid;
    assign out_if.data  = r_out;

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pdm_pkg::ST_LOAD;
            r_maxd     <= '0;
            r_n        <= '0;
            r_k        <= '0;
            r_m        <= '0;
            r_surv     <= '0;
            r_ovalid   <= 1'b0;
            r_cmp_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_pend <= (r_state == pdm_pkg::ST_INNER_CMP);
            if (i_cfg_we) r_maxd <= i_cfg_wdata;
            if (emit_load) r_ovalid <= 1'b1;
            else if (out_acc) r_ovalid <= 1'b0;
            unique case (r_state)
                pdm_pkg::ST_LOAD: begin
                    if (in_acc && load_room) r_n <= r_n + 1'b1;
                    r_k  <= '0;
                    r_m  <= '0;
                    r_d2 <= 18'(r_maxd * r_maxd);
                end
                pdm_pkg::ST_RANK_KEY: begin
                    if (r_k >= r_n) begin
                        r_k    <= '0;
                        r_surv <= '0;
                    end else begin
                        r_m <= r_k;
                    end
                end
                pdm_pkg::ST_RANK_RD: begin
                    // key count arrives here on the first pass
                    if (r_m == r_k) r_key_cnt <= cnt_rd;
                end
                pdm_pkg::ST_RANK_CNT: r_ord_q <= ord_rd;
                pdm_pkg::ST_RANK_CMP: begin
                    if (rank_shift) r_m <= r_m - 1'b1;
                end
                pdm_pkg::ST_RANK_PUT: r_k <= r_k + 1'b1;
                pdm_pkg::ST_OUTER_RD: begin
                    if (r_k >= r_n) r_k <= '0;
                end
                pdm_pkg::ST_OUTER_COL: begin
                    if (col_rd[24]) begin
                        r_surv    <= r_surv + 1'b1;
                        r_m       <= r_k + 1'b1;
                        r_rep_col <= col_rd[23:0];
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                pdm_pkg::ST_INNER_RD: begin
                    if (r_m >= r_n) r_k <= r_k + 1'b1;
                end
                pdm_pkg::ST_INNER_CMP: begin
                    r_q <= ord_rd;
                    r_m <= r_m + 1'b1;
                end
                pdm_pkg::ST_EMIT_RD: begin
                    if (r_k >= r_n) r_n <= '0;
                end
                pdm_pkg::ST_EMIT: begin
                    if (emit_load) begin
                        r_out.entry_index    <= r_k[IW-1:0];
                        r_out.out_red        <= col_rd[23:16];
                        r_out.out_green      <= col_rd[15:8];
                        r_out.out_blue       <= col_rd[7:0];
                        r_out.is_survivor    <= col_rd[24];
                        r_out.survivor_total <= 7'(r_surv);
                        r_out.loaded_total   <= 7'(r_n);
                        r_out.last_result    <= (r_k + 1'b1 == r_n);
                        r_k <= r_k + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
